[hw/rtl/sbpr_pkg.sv]
// ----------------------------------------------------------------------------
// sbpr_pkg
// Shared types, codes and helpers for the block pool and ring manager.
// ----------------------------------------------------------------------------
package sbpr_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 16;
	localparam int CCNT_W     = 7;   // width of the count registers as written
	localparam int PROD_W     = IDX_W + LEN_W;
	localparam int RING_W     = ADDR_W + LEN_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int STATUS_W   = 3;
	localparam int NOTE_W     = 2;
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 56;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;

	// Queue numbering
	localparam logic [1:0] Q_TXPOOL = 2'd0;
	localparam logic [1:0] Q_TXRING = 2'd1;
	localparam logic [1:0] Q_RXPOOL = 2'd2;
	localparam logic [1:0] Q_RXRING = 2'd3;

	typedef enum logic [1:0] {
		CMD_SEND     = 2'd0,
		CMD_RECV     = 2'd1,
		CMD_PEER_RET = 2'd2,
		CMD_PEER_DLV = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_LINK_BUSY   = 3'd1,
		ST_TOO_LONG    = 3'd2,
		ST_NO_FREE     = 3'd3,
		ST_RING_FULL   = 3'd4,
		ST_RING_EMPTY  = 3'd5,
		ST_EP_CLOSED   = 3'd6,
		ST_POOL_FULL   = 3'd7
	} status_t;

	localparam logic [NOTE_W-1:0] NOTE_NONE    = 2'd0;
	localparam logic [NOTE_W-1:0] NOTE_SEND    = 2'd1;
	localparam logic [NOTE_W-1:0] NOTE_RELEASE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TX_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TX_SIZE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RX_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RX_SIZE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LINK      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EP_OPEN   = 3'd6;

	localparam logic [CCNT_W-1:0] RST_COUNT = 7'd64;
	localparam len_t              RST_SIZE  = 16'd1024;

	typedef enum logic [1:0] {
		FSM_IDLE   = 2'd0,
		FSM_LOOKUP = 2'd1,
		FSM_FINISH = 2'd2
	} fsm_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;   // latch the incoming transfer
		logic lookup;   // read the queue memories, evaluate the checks
		logic commit;   // write back and load the result register
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy; // result register holds a transfer not taken this cycle
	} dp_stat_t;

	// 0 acts as 1, values above MAX_BLOCKS act as MAX_BLOCKS
	function automatic cnt_t clamp_count(logic [CCNT_W-1:0] v);
		if (v == '0)
			return cnt_t'(1);
		if (32'(v) > MAX_BLOCKS)
			return cnt_t'(MAX_BLOCKS);
		return cnt_t'(v);
	endfunction

	// Ring index advance, wrapping at the configured count
	function automatic idx_t next_idx(idx_t s, cnt_t c);
		cnt_t n;
		n = cnt_t'(s) + cnt_t'(1);
		return (n >= c) ? '0 : idx_t'(n);
	endfunction

endpackage

[hw/rtl/shared_block_pool_ring_manager_core.sv]
// ----------------------------------------------------------------------------
// shared_block_pool_ring_manager_core
// Free-pool and descriptor-ring manager for fixed-size shared data blocks.
// ----------------------------------------------------------------------------
// Sequence: a taken command passes the look-up state (registered read of the
//   descriptor memories) and the finish state (write-back, result register load).
// A new command is taken only as the previous one retires from the finish state,
//   which holds while the result register is still occupied.
// Reset: asynchronous, resets the sequencer, indices, fill levels and pool
//   valid bits at once; no clearing pass, the block is ready straight away.
// ----------------------------------------------------------------------------
//
// Four queues of block descriptors:
//   transmit free pool, transmit ring, receive free pool, receive ring.
// Every command moves one descriptor from one queue to another:
//   local send      : tx pool -> tx ring   (send notice to the peer)
//   local receive   : rx ring -> rx pool   (release notice to the peer)
//   peer tx return  : tx ring -> tx pool
//   peer rx deliver : rx pool -> rx ring
// Each queue lives in its own RAM, so a command reads one RAM and writes a
// different one. Pool slots that were never written since the last layout
// change read as their layout address (base + slot * size), tracked by one
// valid bit per pool slot. Writing a count, size or base register rebuilds
// all four queues: indices to zero, pools full, rings empty.
// On any error status nothing changes and the result carries zero address,
// zero length and no notice.
//
module shared_block_pool_ring_manager_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// command side
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sbpr_pkg::IN_DATA_W-1:0]      s_tdata,  // [15:0] length
	input  logic [sbpr_pkg::IN_USER_W-1:0]      s_tuser,  // [1:0] cmd
	// result side
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] status, [34:3] block_address, [50:35] block_length,
	// [52:51] notify, [55:53] zero
	output logic [sbpr_pkg::OUT_DATA_W-1:0]     m_tdata,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [sbpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sbpr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	sbpr_pkg::ctrl_cmd_t ctl;
	sbpr_pkg::dp_stat_t  sts;

	// Sequencer: idle -> look-up -> finish; finish holds while the result
	// register is still occupied and takes the next transfer as it retires.
	sbpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Datapath: registers, queue bookkeeping, descriptor RAMs, result register
	sbpr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

endmodule

[hw/rtl/sbpr_ram.sv]
// ----------------------------------------------------------------------------
// sbpr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/sbpr_ctrl.sv]
// ----------------------------------------------------------------------------
// sbpr_ctrl
// Sequencer: accept, look up, commit.
// ----------------------------------------------------------------------------
module sbpr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  sbpr_pkg::dp_stat_t   sts,
	output sbpr_pkg::ctrl_cmd_t  ctl
);

	sbpr_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sbpr_pkg::FSM_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		ctl        = '0;
		unique case (state_q)
			sbpr_pkg::FSM_IDLE: begin
				s_tready = 1'b1;
			end
			sbpr_pkg::FSM_LOOKUP: begin
				ctl.lookup = 1'b1;
				state_d    = sbpr_pkg::FSM_FINISH;
			end
			sbpr_pkg::FSM_FINISH: begin
				// next transfer may enter as this one retires
				if (!sts.out_busy) begin
					ctl.commit = 1'b1;
					s_tready   = 1'b1;
					state_d    = sbpr_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = sbpr_pkg::FSM_IDLE;
			end
		endcase
		ctl.accept = s_tvalid && s_tready;
		if (ctl.accept)
			state_d = sbpr_pkg::FSM_LOOKUP;
	end

endmodule

[hw/rtl/sbpr_datapath.sv]
// ----------------------------------------------------------------------------
// sbpr_datapath
// Config registers, queue indices and fill levels, descriptor memories and
// the result register.
// ----------------------------------------------------------------------------
module sbpr_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sbpr_pkg::ctrl_cmd_t                   ctl,
	output sbpr_pkg::dp_stat_t                    sts,
	input  logic [sbpr_pkg::IN_DATA_W-1:0]        s_tdata,
	input  logic [sbpr_pkg::IN_USER_W-1:0]        s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [sbpr_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                  cfg_we,
	input  logic [sbpr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sbpr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	// configuration
	sbpr_pkg::cnt_t  tx_cnt_q, rx_cnt_q;
	sbpr_pkg::len_t  tx_size_q, rx_size_q;
	sbpr_pkg::addr_t base_q, rx_base_q;
	logic            link_q, ep_open_q;

	// queue bookkeeping
	sbpr_pkg::idx_t rd_idx_q [4];
	sbpr_pkg::idx_t wr_idx_q [4];
	sbpr_pkg::cnt_t fill_q   [4];
	logic [sbpr_pkg::MAX_BLOCKS-1:0] txp_vld_q, rxp_vld_q;

	// item in flight
	sbpr_pkg::cmd_t                cmd_q;
	sbpr_pkg::len_t                len_q;
	sbpr_pkg::status_t             status_q, status_d;
	logic [sbpr_pkg::PROD_W-1:0]   prod_q;
	logic                          txp_hit_q, rxp_hit_q;

	// result register
	logic                          out_vld_q;
	sbpr_pkg::status_t             out_status_q;
	sbpr_pkg::addr_t               out_addr_q;
	sbpr_pkg::len_t                out_len_q;
	logic [sbpr_pkg::NOTE_W-1:0]   out_note_q;

	// memory ports
	logic [sbpr_pkg::ADDR_W-1:0] txp_rdata, rxp_rdata;
	logic [sbpr_pkg::RING_W-1:0] txr_rdata, rxr_rdata;
	logic                        txp_we, rxp_we, txr_we, rxr_we;
	logic [sbpr_pkg::ADDR_W-1:0] txp_wdata, rxp_wdata;
	logic [sbpr_pkg::RING_W-1:0] txr_wdata, rxr_wdata;

	logic                        layout;
	sbpr_pkg::cnt_t              tx_cnt_new, rx_cnt_new;
	logic                        commit_ok;
	logic [1:0]                  src_q, dst_q;
	sbpr_pkg::addr_t             tx_pool_addr, rx_pool_addr;
	sbpr_pkg::addr_t             res_addr;
	sbpr_pkg::len_t              res_len;
	logic [sbpr_pkg::NOTE_W-1:0] res_note;
	logic [sbpr_pkg::IDX_W-1:0]  prod_idx;
	sbpr_pkg::len_t              prod_size;

	// ---------------------------------------------------------------- config
	always_comb begin
		layout     = 1'b0;
		tx_cnt_new = tx_cnt_q;
		rx_cnt_new = rx_cnt_q;
		if (cfg_we) begin
			unique case (cfg_index) inside
				sbpr_pkg::REG_TX_COUNT: begin
					layout     = 1'b1;
					tx_cnt_new = sbpr_pkg::clamp_count(cfg_wdata[sbpr_pkg::CCNT_W-1:0]);
				end
				sbpr_pkg::REG_RX_COUNT: begin
					layout     = 1'b1;
					rx_cnt_new = sbpr_pkg::clamp_count(cfg_wdata[sbpr_pkg::CCNT_W-1:0]);
				end
				sbpr_pkg::REG_TX_SIZE, sbpr_pkg::REG_RX_SIZE, sbpr_pkg::REG_BASE: begin
					layout = 1'b1;
				end
				default: begin
					layout = 1'b0;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- checks
	always_comb begin
		status_d = sbpr_pkg::ST_OK;
		case (cmd_q)
			sbpr_pkg::CMD_SEND: begin
				if (!link_q)
					status_d = sbpr_pkg::ST_LINK_BUSY;
				else if (len_q > tx_size_q)
					status_d = sbpr_pkg::ST_TOO_LONG;
				else if (fill_q[sbpr_pkg::Q_TXPOOL] == '0)
					status_d = sbpr_pkg::ST_NO_FREE;
				else if (fill_q[sbpr_pkg::Q_TXRING] >= tx_cnt_q)
					status_d = sbpr_pkg::ST_RING_FULL;
			end
			sbpr_pkg::CMD_RECV: begin
				if (fill_q[sbpr_pkg::Q_RXRING] == '0)
					status_d = sbpr_pkg::ST_RING_EMPTY;
				else if (!ep_open_q)
					status_d = sbpr_pkg::ST_EP_CLOSED;
				else if (fill_q[sbpr_pkg::Q_RXPOOL] >= rx_cnt_q)
					status_d = sbpr_pkg::ST_POOL_FULL;
			end
			sbpr_pkg::CMD_PEER_RET: begin
				if (fill_q[sbpr_pkg::Q_TXRING] == '0)
					status_d = sbpr_pkg::ST_RING_EMPTY;
				else if (fill_q[sbpr_pkg::Q_TXPOOL] >= tx_cnt_q)
					status_d = sbpr_pkg::ST_POOL_FULL;
			end
			default: begin
				if (len_q > rx_size_q)
					status_d = sbpr_pkg::ST_TOO_LONG;
				else if (fill_q[sbpr_pkg::Q_RXPOOL] == '0)
					status_d = sbpr_pkg::ST_NO_FREE;
				else if (fill_q[sbpr_pkg::Q_RXRING] >= rx_cnt_q)
					status_d = sbpr_pkg::ST_RING_FULL;
			end
		endcase
	end

	// pool slot offset, only used by the commands that take from a pool
	always_comb begin
		if (cmd_q == sbpr_pkg::CMD_SEND) begin
			prod_idx  = rd_idx_q[sbpr_pkg::Q_TXPOOL];
			prod_size = tx_size_q;
		end else begin
			prod_idx  = rd_idx_q[sbpr_pkg::Q_RXPOOL];
			prod_size = rx_size_q;
		end
	end

	// ---------------------------------------------------------------- commit
	// never-written pool slots read as their address in the current layout
	assign tx_pool_addr = txp_hit_q ? txp_rdata : base_q + sbpr_pkg::ADDR_W'(prod_q);
	assign rx_pool_addr = rxp_hit_q ? rxp_rdata : rx_base_q + sbpr_pkg::ADDR_W'(prod_q);

	assign commit_ok = ctl.commit && (status_q == sbpr_pkg::ST_OK);

	always_comb begin
		res_addr = '0;
		res_len  = '0;
		res_note = sbpr_pkg::NOTE_NONE;
		src_q    = sbpr_pkg::Q_TXPOOL;
		dst_q    = sbpr_pkg::Q_TXRING;
		case (cmd_q)
			sbpr_pkg::CMD_SEND: begin
				res_addr = tx_pool_addr;
				res_len  = len_q;
				res_note = sbpr_pkg::NOTE_SEND;
			end
			sbpr_pkg::CMD_RECV: begin
				src_q    = sbpr_pkg::Q_RXRING;
				dst_q    = sbpr_pkg::Q_RXPOOL;
				res_addr = rxr_rdata[sbpr_pkg::ADDR_W-1:0];
				res_len  = rxr_rdata[sbpr_pkg::RING_W-1:sbpr_pkg::ADDR_W];
				res_note = sbpr_pkg::NOTE_RELEASE;
			end
			sbpr_pkg::CMD_PEER_RET: begin
				src_q    = sbpr_pkg::Q_TXRING;
				dst_q    = sbpr_pkg::Q_TXPOOL;
				res_addr = txr_rdata[sbpr_pkg::ADDR_W-1:0];
				res_len  = txr_rdata[sbpr_pkg::RING_W-1:sbpr_pkg::ADDR_W];
			end
			default: begin
				src_q    = sbpr_pkg::Q_RXPOOL;
				dst_q    = sbpr_pkg::Q_RXRING;
				res_addr = rx_pool_addr;
				res_len  = len_q;
			end
		endcase
	end

	assign txr_we    = commit_ok && (cmd_q == sbpr_pkg::CMD_SEND);
	assign rxp_we    = commit_ok && (cmd_q == sbpr_pkg::CMD_RECV);
	assign txp_we    = commit_ok && (cmd_q == sbpr_pkg::CMD_PEER_RET);
	assign rxr_we    = commit_ok && (cmd_q == sbpr_pkg::CMD_PEER_DLV);
	assign txr_wdata = {len_q, res_addr};
	assign rxr_wdata = {len_q, res_addr};
	assign txp_wdata = res_addr;
	assign rxp_wdata = res_addr;

	// ---------------------------------------------------------------- state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_cnt_q  <= sbpr_pkg::clamp_count(sbpr_pkg::RST_COUNT);
			rx_cnt_q  <= sbpr_pkg::clamp_count(sbpr_pkg::RST_COUNT);
			tx_size_q <= sbpr_pkg::RST_SIZE;
			rx_size_q <= sbpr_pkg::RST_SIZE;
			base_q    <= '0;
			rx_base_q <= sbpr_pkg::ADDR_W'(sbpr_pkg::clamp_count(sbpr_pkg::RST_COUNT))
				* sbpr_pkg::ADDR_W'(sbpr_pkg::RST_SIZE);
			link_q    <= 1'b0;
			ep_open_q <= 1'b0;
			txp_vld_q <= '0;
			rxp_vld_q <= '0;
			out_vld_q <= 1'b0;
			for (int q = 0; q < 4; q++) begin
				rd_idx_q[q] <= '0;
				wr_idx_q[q] <= '0;
			end
			fill_q[sbpr_pkg::Q_TXPOOL] <= sbpr_pkg::clamp_count(sbpr_pkg::RST_COUNT);
			fill_q[sbpr_pkg::Q_TXRING] <= '0;
			fill_q[sbpr_pkg::Q_RXPOOL] <= sbpr_pkg::clamp_count(sbpr_pkg::RST_COUNT);
			fill_q[sbpr_pkg::Q_RXRING] <= '0;
		end else begin
			// receive blocks sit straight after the transmit blocks
			rx_base_q <= base_q + sbpr_pkg::ADDR_W'(tx_cnt_q) * sbpr_pkg::ADDR_W'(tx_size_q);
			if (cfg_we) begin
				unique case (cfg_index)
					sbpr_pkg::REG_TX_COUNT: tx_cnt_q  <= tx_cnt_new;
					sbpr_pkg::REG_TX_SIZE:  tx_size_q <= cfg_wdata[sbpr_pkg::LEN_W-1:0];
					sbpr_pkg::REG_RX_COUNT: rx_cnt_q  <= rx_cnt_new;
					sbpr_pkg::REG_RX_SIZE:  rx_size_q <= cfg_wdata[sbpr_pkg::LEN_W-1:0];
					sbpr_pkg::REG_BASE:     base_q    <= cfg_wdata[sbpr_pkg::ADDR_W-1:0];
					sbpr_pkg::REG_LINK:     link_q    <= cfg_wdata[0];
					sbpr_pkg::REG_EP_OPEN:  ep_open_q <= cfg_wdata[0];
					default: ;
				endcase
			end

			if (layout) begin
				// rebuild all four queues with the new layout
				txp_vld_q <= '0;
				rxp_vld_q <= '0;
				for (int q = 0; q < 4; q++) begin
					rd_idx_q[q] <= '0;
					wr_idx_q[q] <= '0;
				end
				fill_q[sbpr_pkg::Q_TXPOOL] <= tx_cnt_new;
				fill_q[sbpr_pkg::Q_TXRING] <= '0;
				fill_q[sbpr_pkg::Q_RXPOOL] <= rx_cnt_new;
				fill_q[sbpr_pkg::Q_RXRING] <= '0;
			end else if (commit_ok) begin
				for (int q = 0; q < 4; q++) begin
					if (2'(q) == src_q) begin
						rd_idx_q[q] <= sbpr_pkg::next_idx(rd_idx_q[q],
							(q < 2) ? tx_cnt_q : rx_cnt_q);
						fill_q[q]   <= fill_q[q] - sbpr_pkg::cnt_t'(1);
					end
					if (2'(q) == dst_q) begin
						wr_idx_q[q] <= sbpr_pkg::next_idx(wr_idx_q[q],
							(q < 2) ? tx_cnt_q : rx_cnt_q);
						fill_q[q]   <= fill_q[q] + sbpr_pkg::cnt_t'(1);
					end
				end
				if (txp_we)
					txp_vld_q[wr_idx_q[sbpr_pkg::Q_TXPOOL]] <= 1'b1;
				if (rxp_we)
					rxp_vld_q[wr_idx_q[sbpr_pkg::Q_RXPOOL]] <= 1'b1;
			end

			if (ctl.commit)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= sbpr_pkg::cmd_t'(s_tuser);
			len_q <= s_tdata[sbpr_pkg::LEN_W-1:0];
		end
		if (ctl.lookup) begin
			status_q  <= status_d;
			prod_q    <= sbpr_pkg::PROD_W'(prod_idx) * sbpr_pkg::PROD_W'(prod_size);
			txp_hit_q <= txp_vld_q[rd_idx_q[sbpr_pkg::Q_TXPOOL]];
			rxp_hit_q <= rxp_vld_q[rd_idx_q[sbpr_pkg::Q_RXPOOL]];
		end
		if (ctl.commit) begin
			out_status_q <= status_q;
			out_addr_q   <= commit_ok ? res_addr : '0;
			out_len_q    <= commit_ok ? res_len  : '0;
			out_note_q   <= commit_ok ? res_note : sbpr_pkg::NOTE_NONE;
		end
	end

	// ---------------------------------------------------------------- memories
	sbpr_ram #(.WIDTH(sbpr_pkg::ADDR_W), .DEPTH(sbpr_pkg::MAX_BLOCKS)) u_txp_ram (
		.clk   (clk),
		.we    (txp_we),
		.waddr (wr_idx_q[sbpr_pkg::Q_TXPOOL]),
		.wdata (txp_wdata),
		.re    (ctl.lookup),
		.raddr (rd_idx_q[sbpr_pkg::Q_TXPOOL]),
		.rdata (txp_rdata)
	);

	sbpr_ram #(.WIDTH(sbpr_pkg::RING_W), .DEPTH(sbpr_pkg::MAX_BLOCKS)) u_txr_ram (
		.clk   (clk),
		.we    (txr_we),
		.waddr (wr_idx_q[sbpr_pkg::Q_TXRING]),
		.wdata (txr_wdata),
		.re    (ctl.lookup),
		.raddr (rd_idx_q[sbpr_pkg::Q_TXRING]),
		.rdata (txr_rdata)
	);

	sbpr_ram #(.WIDTH(sbpr_pkg::ADDR_W), .DEPTH(sbpr_pkg::MAX_BLOCKS)) u_rxp_ram (
		.clk   (clk),
		.we    (rxp_we),
		.waddr (wr_idx_q[sbpr_pkg::Q_RXPOOL]),
		.wdata (rxp_wdata),
		.re    (ctl.lookup),
		.raddr (rd_idx_q[sbpr_pkg::Q_RXPOOL]),
		.rdata (rxp_rdata)
	);

	sbpr_ram #(.WIDTH(sbpr_pkg::RING_W), .DEPTH(sbpr_pkg::MAX_BLOCKS)) u_rxr_ram (
		.clk   (clk),
		.we    (rxr_we),
		.waddr (wr_idx_q[sbpr_pkg::Q_RXRING]),
		.wdata (rxr_wdata),
		.re    (ctl.lookup),
		.raddr (rd_idx_q[sbpr_pkg::Q_RXRING]),
		.rdata (rxr_rdata)
	);

	// ---------------------------------------------------------------- outputs
	assign sts.out_busy = out_vld_q && !m_tready;
	assign m_tvalid     = out_vld_q;
	assign m_tdata      = {3'b000, out_note_q, out_len_q, out_addr_q, out_status_q};

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the block pool and ring manager core. Commands go
// in as stream transfers; a local copy of the four descriptor queues works out
// each result, which is compared field by field with the result transfer.
// ----------------------------------------------------------------------------
module tb;

	import sbpr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1300;
	localparam int MAX_REPORTS  = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind it

	typedef struct {
		status_t           status;
		addr_t             addr;
		len_t              len;
		logic [NOTE_W-1:0] note;
	} ring_result_t;

	// ------------------------------------------------------------------------
	// DUT hook-up
	// ------------------------------------------------------------------------
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;  // [15:0] length
	logic [IN_USER_W-1:0]  s_tuser   = '0;  // [1:0] cmd
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// [2:0] status, [34:3] block_address, [50:35] block_length,
	// [52:51] notify, [55:53] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	shared_block_pool_ring_manager_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Local copy of the block layout and the four queues
	// ------------------------------------------------------------------------
	int unsigned tx_blocks, rx_blocks;
	len_t        tx_bytes, rx_bytes;
	addr_t       pool_base;
	bit          link_up, ep_open;

	addr_t       tx_free   [MAX_BLOCKS];
	addr_t       tx_q_addr [MAX_BLOCKS];
	len_t        tx_q_len  [MAX_BLOCKS];
	addr_t       rx_free   [MAX_BLOCKS];
	addr_t       rx_q_addr [MAX_BLOCKS];
	len_t        rx_q_len  [MAX_BLOCKS];
	int unsigned head [4];
	int unsigned tail [4];
	int unsigned level[4];

	ring_result_t pending[$];   // results owed by the DUT, oldest first
	int           n_bad;
	int           n_sent;
	int           n_cycles;
	bit           quiet_in, quiet_out;  // phases with no idling on that side

	// 0 behaves as one block, anything past the table size as a full table
	function automatic int unsigned fit_count(logic [CCNT_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > MAX_BLOCKS)
			return MAX_BLOCKS;
		return int'(v);
	endfunction

	// Pools full and laid out back to back (tx first), rings empty
	function automatic void relayout();
		addr_t a;
		a = pool_base;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			tx_free[i]   = '0;
			rx_free[i]   = '0;
			tx_q_addr[i] = '0;
			tx_q_len[i]  = '0;
			rx_q_addr[i] = '0;
			rx_q_len[i]  = '0;
		end
		for (int i = 0; i < tx_blocks; i++) begin
			tx_free[i] = a;
			a += addr_t'(tx_bytes);
		end
		for (int i = 0; i < rx_blocks; i++) begin
			rx_free[i] = a;
			a += addr_t'(rx_bytes);
		end
		for (int q = 0; q < 4; q++) begin
			head[q] = 0;
			tail[q] = 0;
		end
		level[Q_TXPOOL] = tx_blocks;
		level[Q_TXRING] = 0;
		level[Q_RXPOOL] = rx_blocks;
		level[Q_RXRING] = 0;
	endfunction

	function automatic void restore_defaults();
		tx_blocks = fit_count(RST_COUNT);
		rx_blocks = fit_count(RST_COUNT);
		tx_bytes  = RST_SIZE;
		rx_bytes  = RST_SIZE;
		pool_base = '0;
		link_up   = 1'b0;
		ep_open   = 1'b0;
		relayout();
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_TX_COUNT: begin
				tx_blocks = fit_count(v[CCNT_W-1:0]);
				relayout();
			end
			REG_TX_SIZE: begin
				tx_bytes = v[LEN_W-1:0];
				relayout();
			end
			REG_RX_COUNT: begin
				rx_blocks = fit_count(v[CCNT_W-1:0]);
				relayout();
			end
			REG_RX_SIZE: begin
				rx_bytes = v[LEN_W-1:0];
				relayout();
			end
			REG_BASE: begin
				pool_base = v;
				relayout();
			end
			REG_LINK:    link_up = v[0];
			REG_EP_OPEN: ep_open = v[0];
			default: ;
		endcase
	endfunction

	function automatic int unsigned take_slot(logic [1:0] q, int unsigned count);
		int unsigned s;
		s = head[q] % count;
		head[q] = (s + 1 >= count) ? 0 : s + 1;
		level[q]--;
		return s;
	endfunction

	function automatic int unsigned put_slot(logic [1:0] q, int unsigned count);
		int unsigned s;
		s = tail[q] % count;
		tail[q] = (s + 1 >= count) ? 0 : s + 1;
		level[q]++;
		return s;
	endfunction

	// Moves one descriptor as the command asks and returns what the DUT must
	// report. Errors leave every queue as it was.
	function automatic ring_result_t ring_outcome(cmd_t op, len_t len);
		ring_result_t r;
		int unsigned  s, d;
		r.status = ST_OK;
		r.addr   = '0;
		r.len    = '0;
		r.note   = NOTE_NONE;
		case (op)
			CMD_SEND: begin
				if (!link_up)
					r.status = ST_LINK_BUSY;
				else if (len > tx_bytes)
					r.status = ST_TOO_LONG;
				else if (level[Q_TXPOOL] == 0)
					r.status = ST_NO_FREE;
				else if (level[Q_TXRING] >= tx_blocks)
					r.status = ST_RING_FULL;
				else begin
					s = take_slot(Q_TXPOOL, tx_blocks);
					r.addr = tx_free[s];
					d = put_slot(Q_TXRING, tx_blocks);
					tx_q_addr[d] = r.addr;
					tx_q_len[d]  = len;
					r.len  = len;
					r.note = NOTE_SEND;
				end
			end
			CMD_RECV: begin
				if (level[Q_RXRING] == 0)
					r.status = ST_RING_EMPTY;
				else if (!ep_open)
					r.status = ST_EP_CLOSED;
				else if (level[Q_RXPOOL] >= rx_blocks)
					r.status = ST_POOL_FULL;
				else begin
					s = take_slot(Q_RXRING, rx_blocks);
					r.addr = rx_q_addr[s];
					r.len  = rx_q_len[s];
					d = put_slot(Q_RXPOOL, rx_blocks);
					rx_free[d] = r.addr;
					r.note = NOTE_RELEASE;
				end
			end
			CMD_PEER_RET: begin
				if (level[Q_TXRING] == 0)
					r.status = ST_RING_EMPTY;
				else if (level[Q_TXPOOL] >= tx_blocks)
					r.status = ST_POOL_FULL;
				else begin
					s = take_slot(Q_TXRING, tx_blocks);
					r.addr = tx_q_addr[s];
					r.len  = tx_q_len[s];
					d = put_slot(Q_TXPOOL, tx_blocks);
					tx_free[d] = r.addr;
				end
			end
			default: begin
				if (len > rx_bytes)
					r.status = ST_TOO_LONG;
				else if (level[Q_RXPOOL] == 0)
					r.status = ST_NO_FREE;
				else if (level[Q_RXRING] >= rx_blocks)
					r.status = ST_RING_FULL;
				else begin
					s = take_slot(Q_RXPOOL, rx_blocks);
					r.addr = rx_free[s];
					d = put_slot(Q_RXRING, rx_blocks);
					rx_q_addr[d] = r.addr;
					rx_q_len[d]  = len;
					r.len = len;
				end
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	function automatic int draw_gap(bit quiet);
		if (quiet || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	// One command transfer. tvalid stays up between back-to-back commands so
	// it never sees two updates in one step.
	task automatic send_cmd(cmd_t op, len_t len);
		int gap;
		gap = draw_gap(quiet_in);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= len;
		do
			@(posedge clk);
		while (!s_tready);
		pending.push_back(ring_outcome(op, len));
		n_sent++;
	endtask

	// Drop tvalid and let every owed result come back; the core is idle then
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, v);
		@(posedge clk);
	endtask

	// Result side: a fresh stall before each transfer
	initial begin : result_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap(quiet_out);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
		end
	end

	// ------------------------------------------------------------------------
	// Checker: every result transfer against the oldest owed result
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		ring_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				n_bad++;
				if (n_bad <= MAX_REPORTS)
					$display("tb: unexpected result transfer, data %h", m_tdata);
			end else begin
				want = pending.pop_front();
				if (m_tdata[2:0] !== want.status || m_tdata[34:3] !== want.addr ||
						m_tdata[50:35] !== want.len || m_tdata[52:51] !== want.note ||
						m_tdata[55:53] !== 3'b000) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("tb: mismatch: exp st %0d addr %h len %h note %0d, got st %0d addr %h len %h note %0d pad %b",
							want.status, want.addr, want.len, want.note,
							m_tdata[2:0], m_tdata[34:3], m_tdata[50:35], m_tdata[52:51],
							m_tdata[55:53]);
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Default layout, link and endpoint closed, then opened
	task automatic test_reset_layout();
		send_cmd(CMD_SEND, 16'h0000);       // link busy
		send_cmd(CMD_RECV, 16'h0000);       // rx ring empty
		send_cmd(CMD_PEER_RET, 16'hFFFF);   // tx ring empty
		send_cmd(CMD_PEER_DLV, 16'hFFFF);   // longer than an rx block
		send_cmd(CMD_PEER_DLV, RST_SIZE);   // first rx block, just after tx blocks
		send_cmd(CMD_RECV, 16'h0000);       // endpoint closed
		wait_drained();
		write_reg(REG_LINK, 32'h1);
		write_reg(REG_EP_OPEN, 32'h1);
		send_cmd(CMD_SEND, RST_SIZE + 16'd1);
		send_cmd(CMD_SEND, RST_SIZE);
		send_cmd(CMD_RECV, 16'h0000);
		send_cmd(CMD_PEER_RET, 16'h0000);
	endtask

	// One block per side, sizes at the extremes, layout wrapping round 2^32.
	// Ring full and pool full never come up: pool and ring together always
	// hold every block of their side.
	task automatic test_small_rings();
		wait_drained();
		write_reg(REG_TX_COUNT, 32'h0);     // acts as one block
		write_reg(REG_RX_COUNT, 32'h1);
		write_reg(REG_TX_SIZE, 32'hFFFF);
		write_reg(REG_RX_SIZE, 32'h0);
		write_reg(REG_BASE, 32'hFFFF_FFF0);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send_cmd(CMD_SEND, 16'hFFFF);
		send_cmd(CMD_SEND, 16'h0000);       // pool empty
		send_cmd(CMD_PEER_RET, 16'h0000);
		send_cmd(CMD_PEER_RET, 16'h0000);   // ring empty
		send_cmd(CMD_PEER_DLV, 16'h0001);   // too long for a zero-byte block
		send_cmd(CMD_PEER_DLV, 16'h0000);
		send_cmd(CMD_PEER_DLV, 16'h0000);   // rx pool empty
		send_cmd(CMD_RECV, 16'h0000);
		wait_drained();
		write_reg(REG_LINK, 32'h0);
		send_cmd(CMD_SEND, 16'h0000);
	endtask

	function automatic logic [CFG_DATA_W-1:0] any_count();
		logic [CFG_DATA_W-1:0] v;
		case ($urandom_range(0, 7))
			0:       v = 0;
			1:       v = 1;
			2:       v = MAX_BLOCKS;
			3:       v = $urandom_range(MAX_BLOCKS + 1, 127);
			4, 5:    v = $urandom_range(2, 8);
			default: v = $urandom_range(1, MAX_BLOCKS);
		endcase
		if ($urandom_range(0, 7) == 0)
			v |= $urandom() << CCNT_W;      // bits above the register
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] any_size();
		logic [CFG_DATA_W-1:0] v;
		case ($urandom_range(0, 7))
			0:       v = 0;
			1:       v = 1;
			2:       v = 32'hFFFF;
			3:       v = $urandom_range(1, 64);
			default: v = $urandom_range(1, 65535);
		endcase
		if ($urandom_range(0, 7) == 0)
			v |= $urandom() << LEN_W;
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] any_flag();
		logic [CFG_DATA_W-1:0] v;
		v = ($urandom_range(0, 6) != 0) ? 32'h1 : 32'h0;
		if ($urandom_range(0, 3) == 0)
			v |= $urandom() & 32'hFFFF_FFFE;
		return v;
	endfunction

	// New settings between phases; an unwritten layout keeps the queue state
	task automatic random_settings();
		wait_drained();
		if ($urandom_range(0, 9) < 7) write_reg(REG_TX_COUNT, any_count());
		if ($urandom_range(0, 9) < 7) write_reg(REG_RX_COUNT, any_count());
		if ($urandom_range(0, 9) < 6) write_reg(REG_TX_SIZE, any_size());
		if ($urandom_range(0, 9) < 6) write_reg(REG_RX_SIZE, any_size());
		case ($urandom_range(0, 9))
			0:       write_reg(REG_BASE, 32'h0);
			1:       write_reg(REG_BASE, 32'hFFFF_FFFF);
			2, 3, 4: write_reg(REG_BASE, $urandom());
			default: ;
		endcase
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_SPARE, $urandom());
		write_reg(REG_LINK, any_flag());
		write_reg(REG_EP_OPEN, any_flag());
	endtask

	// Stretches that favour one command, so queues fill up and run dry
	task automatic random_burst(int n);
		cmd_t op, fav;
		len_t lim, len;
		fav = CMD_SEND;
		for (int k = 0; k < n; k++) begin
			if (k % 16 == 0)
				fav = cmd_t'($urandom_range(0, 3));
			op  = ($urandom_range(0, 9) < 5) ? fav : cmd_t'($urandom_range(0, 3));
			lim = (op == CMD_SEND) ? tx_bytes : rx_bytes;
			case ($urandom_range(0, 7))
				0:       len = len_t'($urandom());
				1:       len = lim;
				2:       len = (lim == 16'hFFFF) ? lim : lim + 16'd1;
				default: len = len_t'($urandom_range(0, lim));
			endcase
			send_cmd(op, len);
		end
	endtask

	task automatic test_random_traffic();
		int target;
		target = n_sent + RANDOM_ITEMS;
		while (n_sent < target) begin
			random_settings();
			case ($urandom_range(0, 3))
				0: begin
					quiet_in  = 1'b1;
					quiet_out = 1'b1;
				end
				default: begin
					quiet_in  = $urandom_range(0, 4) == 0;
					quiet_out = $urandom_range(0, 4) == 0;
				end
			endcase
			random_burst($urandom_range(40, 120));
		end
		quiet_in  = 1'b0;
		quiet_out = 1'b0;
	endtask

	initial begin
		n_bad     = 0;
		n_sent    = 0;
		n_cycles  = 0;
		quiet_in  = 1'b0;
		quiet_out = 1'b0;
		restore_defaults();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_layout();
		test_small_rings();
		test_random_traffic();
		wait_drained();
		// room for a stray transfer to show up
		repeat (8) @(posedge clk);
		if (n_bad == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

[files.f]
hw/rtl/sbpr_pkg.sv
hw/rtl/sbpr_ram.sv
hw/rtl/sbpr_ctrl.sv
hw/rtl/sbpr_datapath.sv
hw/rtl/shared_block_pool_ring_manager_core.sv
sim/tb.sv
